// ===== hdl/dec96_pkg.sv =====
// Shared constants and types for the 96-bit decimal to text unit.
package dec96_pkg;

    localparam int MANT_W            = 96;  // magnitude width
    localparam int DIGITS            = 29;  // BCD digits needed for 2^96 - 1
    localparam int POS_W             = 5;   // holds a digit position 0..DIGITS
    localparam int CNT_W             = 7;   // counts the magnitude bits
    localparam int SCALE_W           = 8;
    localparam int DEFAULT_MAX_SCALE = 28;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_DABBLE,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctrl;

endpackage

// ===== hdl/dec96_cell.sv =====
// One BCD digit cell of the shift-add-3 conversion chain.
module dec96_cell (
    input  logic                   i_clk,
    input  dec96_pkg::t_cell_ctrl  i_ctrl,
    input  logic                   i_bit_in,
    input  logic [3:0]             i_digit_in,
    output logic                   o_bit_out,
    output logic [3:0]             o_digit
);
    import dec96_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Add three before the shift so the digit carries correctly into the next cell.
    assign w_adj     = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit_out = w_adj[3];
    assign o_digit   = r_digit;

    always_comb begin
        unique case (i_ctrl.op)
            OP_HOLD:   n_digit = r_digit;
            OP_CLEAR:  n_digit = 4'd0;
            OP_DABBLE: n_digit = {w_adj[2:0], i_bit_in};
            OP_SHIFT:  n_digit = i_digit_in;
            default:   n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== hdl/decimal96_to_text_unit.sv =====
// Top level of the 96-bit decimal to ASCII text unit.
//
// Usage: present the magnitude words, scale and sign with start high while
// busy is low; that edge accepts the transaction. The unit then shifts the
// 96-bit magnitude, one bit per cycle, into a chain of 29 BCD digit cells,
// after which the cells shift whole digits toward the top and the top
// digit is printed. Leading zeros are dropped one per cycle, and the print
// phase also emits a '-' for a negative item and a '.' when the scale is
// nonzero. An item keeps the unit busy, and start is ignored, until its
// last character is shown.
// Each character is shown on o_text_char for exactly one cycle with o_strobe
// high; o_last_char marks the final one. The receiver cannot stall, so no
// result is ever held back. A scale above MAX_SCALE gives a single result
// with o_scale_error and o_last_char set in the cycle after acceptance,
// and busy never rises for it. Reset returns the unit to idle with no strobe.
module decimal96_to_text_unit #(
    parameter int MAX_SCALE = dec96_pkg::DEFAULT_MAX_SCALE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   i_mantissa_low,
    input  logic [31:0]                   i_mantissa_mid,
    input  logic [31:0]                   i_mantissa_high,
    input  logic [dec96_pkg::SCALE_W-1:0] i_scale,
    input  logic                          i_negative,
    output logic                          o_strobe,
    output logic [7:0]                    o_text_char,
    output logic                          o_last_char,
    output logic                          o_scale_error
);
    import dec96_pkg::*;

    t_state              r_state, n_state;
    logic [MANT_W-1:0]   r_mant, n_mant;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [POS_W-1:0]    r_scale, n_scale;
    logic                r_neg_pend, n_neg_pend;
    logic                r_dot_done, n_dot_done;
    logic                r_started, n_started;
    logic                r_strobe, n_strobe;
    logic [7:0]          r_char, n_char;
    logic                r_last, n_last;
    logic                r_err, n_err;

    t_cell_ctrl          w_ctrl;
    logic [DIGITS-1:0]   w_carry;
    logic [3:0]          w_digit [DIGITS];
    logic [3:0]          w_top;
    logic                w_accept;
    logic                w_bad_scale;
    logic                w_conv_done;
    logic                w_final_digit;

    assign w_accept    = start && (r_state == S_IDLE);
    assign w_bad_scale = i_scale > SCALE_W'(MAX_SCALE);
    assign w_conv_done = r_cnt == CNT_W'(MANT_W - 1);
    assign w_top       = w_digit[DIGITS-1];

    // The last digit leaves the chain when only one position remains; this is
    // only reached on the branch that prints a digit.
    assign w_final_digit = r_pos == POS_W'(1);

    genvar k;
    generate
        for (k = 0; k < DIGITS; k++) begin : g_cell
            dec96_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_bit_in   ((k == 0) ? r_mant[MANT_W-1] : w_carry[(k == 0) ? 0 : k-1]),
                .i_digit_in ((k == 0) ? 4'd0 : w_digit[(k == 0) ? 0 : k-1]),
                .o_bit_out  (w_carry[k]),
                .o_digit    (w_digit[k])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !w_bad_scale) n_state = S_CONV;
            end
            S_CONV: begin
                if (w_conv_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_neg_pend
                    && !((r_scale != '0) && (r_pos == r_scale) && !r_dot_done)
                    && !(!r_started && (w_top == 4'd0) && (r_pos > (r_scale + POS_W'(1))))
                    && w_final_digit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result control.
    always_comb begin
        w_ctrl.op  = OP_HOLD;
        n_mant     = r_mant;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_scale    = r_scale;
        n_neg_pend = r_neg_pend;
        n_dot_done = r_dot_done;
        n_started  = r_started;
        n_strobe   = 1'b0;
        n_char     = r_char;
        n_last     = r_last;
        n_err      = r_err;

        unique case (r_state)
            S_IDLE: begin
                w_ctrl.op = OP_CLEAR;
                if (w_accept) begin
                    if (w_bad_scale) begin
                        n_strobe = 1'b1;
                        n_char   = CH_NONE;
                        n_last   = 1'b1;
                        n_err    = 1'b1;
                    end else begin
                        n_mant     = {i_mantissa_high, i_mantissa_mid, i_mantissa_low};
                        n_cnt      = '0;
                        n_pos      = POS_W'(DIGITS);
                        n_scale    = i_scale[POS_W-1:0];
                        n_neg_pend = i_negative;
                        n_dot_done = 1'b0;
                        n_started  = 1'b0;
                    end
                end
            end
            S_CONV: begin
                w_ctrl.op = OP_DABBLE;
                n_mant    = {r_mant[MANT_W-2:0], 1'b0};
                n_cnt     = r_cnt + CNT_W'(1);
            end
            S_EMIT: begin
                priority if (r_neg_pend) begin
                    n_strobe   = 1'b1;
                    n_char     = CH_MINUS;
                    n_last     = 1'b0;
                    n_err      = 1'b0;
                    n_neg_pend = 1'b0;
                end else if ((r_scale != '0) && (r_pos == r_scale) && !r_dot_done) begin
                    n_strobe   = 1'b1;
                    n_char     = CH_DOT;
                    n_last     = 1'b0;
                    n_err      = 1'b0;
                    n_dot_done = 1'b1;
                end else if (!r_started && (w_top == 4'd0)
                             && (r_pos > (r_scale + POS_W'(1)))) begin
                    // Leading zero above the integer digit: drop it silently.
                    w_ctrl.op = OP_SHIFT;
                    n_pos     = r_pos - POS_W'(1);
                end else begin
                    w_ctrl.op = OP_SHIFT;
                    n_pos     = r_pos - POS_W'(1);
                    n_started = 1'b1;
                    n_strobe  = 1'b1;
                    n_char    = CH_ZERO + {4'd0, w_top};
                    n_last    = w_final_digit;
                    n_err     = 1'b0;
                end
            end
            default: w_ctrl.op = OP_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mant     <= n_mant;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_scale    <= n_scale;
        r_neg_pend <= n_neg_pend;
        r_dot_done <= n_dot_done;
        r_started  <= n_started;
        r_char     <= n_char;
        r_last     <= n_last;
        r_err      <= n_err;
    end

    assign busy          = r_state != S_IDLE;
    assign o_strobe      = r_strobe;
    assign o_text_char   = r_char;
    assign o_last_char   = r_last;
    assign o_scale_error = r_err;

endmodule

// ===== hdl/dec96_checker.sv =====
// Port-level checks for the decimal to text unit, bound to the top level.
module dec96_checker #(
    parameter int MAX_SCALE = dec96_pkg::DEFAULT_MAX_SCALE
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [dec96_pkg::SCALE_W-1:0] i_scale,
    input logic                          o_strobe,
    input logic [7:0]                    o_text_char,
    input logic                          o_last_char,
    input logic                          o_scale_error
);
    import dec96_pkg::*;

    // A rejected scale yields the error transaction in the next cycle.
    a_bad_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_scale > SCALE_W'(MAX_SCALE)))
        |=> (o_strobe && o_scale_error))
        else $error("scale error result missing");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_scale_error) |-> (o_last_char && (o_text_char == CH_NONE)))
        else $error("malformed scale error result");

    // Text characters only come out of a transaction in progress.
    a_text_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_scale_error) |-> $past(busy))
        else $error("text character without a transaction");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_char) |-> !busy)
        else $error("unit still busy after the last character");

endmodule

bind decimal96_to_text_unit dec96_checker #(.MAX_SCALE(MAX_SCALE)) u_dec96_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_scale       (i_scale),
    .o_strobe      (o_strobe),
    .o_text_char   (o_text_char),
    .o_last_char   (o_last_char),
    .o_scale_error (o_scale_error)
);
